FILE: design/bukstk_pkg.sv
// Package for the bounded unique-key stack: request/response payload types,
// operation and status codes, controller state encoding. No dependencies.
package bukstk_pkg;

    // Operation codes carried in the func field
    localparam logic [1:0] FUNC_PUSH = 2'd0;
    localparam logic [1:0] FUNC_POP  = 2'd1;
    localparam logic [1:0] FUNC_PEEK = 2'd2;

    // Status codes returned with every response
    localparam logic [1:0] STAT_OK    = 2'd0;
    localparam logic [1:0] STAT_DUP   = 2'd1;
    localparam logic [1:0] STAT_FULL  = 2'd2;
    localparam logic [1:0] STAT_EMPTY = 2'd3;

    // Fixed field widths
    localparam int COUNT_W = 9;
    localparam logic [COUNT_W-1:0] MAX_ITEMS_RESET = 9'd100;

    // Input request
    typedef struct packed {
        logic [1:0]         func;
        logic [31:0]        item_key;
        logic [63:0]        item_name;
        logic [7:0]         item_category;
        logic signed [31:0] item_stock;
        logic [39:0]        item_price;
    } cmd_t;

    // Result
    typedef struct packed {
        logic [1:0]         status;
        logic [COUNT_W-1:0] count;
        logic [31:0]        out_key;
        logic [63:0]        out_name;
        logic [7:0]         out_category;
        logic signed [31:0] out_stock;
        logic [39:0]        out_price;
    } rsp_t;

    // Record body kept beside the key memory
    typedef struct packed {
        logic [63:0]        name;
        logic [7:0]         category;
        logic signed [31:0] stock;
        logic [39:0]        price;
    } rec_t;

    localparam int KEY_W = 32;
    localparam int REC_W = $bits(rec_t);

    // Controller states
    typedef enum logic [2:0] {
        S_IDLE,
        S_SEARCH,
        S_DRAIN,
        S_READ,
        S_FINISH
    } state_t;

endpackage

FILE: design/bounded_unique_key_stack.sv
// Top level of the bounded unique-key stack: controller plus key and record
// memories. Depends on bukstk_pkg, bukstk_ram and bukstk_ctrl.
//
// Usage:
//   cmd / cmd_valid / cmd_ready carries push, pop and peek requests.
//   rsp / rsp_valid / rsp_ready returns one response per request with the
//   status and the record count after the operation.
//   cfg_valid / cfg_data writes the max_items limit (cfg_ready is always high);
//   write it only while no request is in flight.
// Sequencing:
//   Requests are handled one at a time. A push scans every live key in the
//   key memory, one read per cycle, before its response is registered (no
//   scan on an empty stack), and the next request can be taken from the
//   cycle after that. Pop and peek read the top entry before responding.
//   The single read port of the key memory sets the pace of the push scan.
// Reset:
//   Count clears to zero and the limit returns to 100; memory contents are
//   not cleared, only entries below the count are ever read.
// Stall:
//   The response sits in an output register until taken; the block keeps
//   accepting a request meanwhile and holds the next result until it drains.
module bounded_unique_key_stack #(
    parameter int DEPTH = 256
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [bukstk_pkg::COUNT_W-1:0] cfg_data,
    input  logic                           cmd_valid,
    output logic                           cmd_ready,
    input  bukstk_pkg::cmd_t               cmd,
    output logic                           rsp_valid,
    input  logic                           rsp_ready,
    output bukstk_pkg::rsp_t               rsp
);

    localparam int AW = $clog2(DEPTH);

    logic                         rd_en;
    logic [AW-1:0]                rd_addr;
    logic                         wr_en;
    logic [AW-1:0]                wr_addr;
    logic [bukstk_pkg::KEY_W-1:0] key_rdata;
    logic [bukstk_pkg::KEY_W-1:0] key_wdata;
    bukstk_pkg::rec_t             rec_rdata;
    bukstk_pkg::rec_t             rec_wdata;

    // Configuration writes are always taken
    assign cfg_ready = 1'b1;

    // Sequencer, search and response register
    bukstk_ctrl #(
        .DEPTH (DEPTH)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_data  (cfg_data),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp),
        .rd_en     (rd_en),
        .rd_addr   (rd_addr),
        .key_rdata (key_rdata),
        .rec_rdata (rec_rdata),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .key_wdata (key_wdata),
        .rec_wdata (rec_wdata)
    );

    // Key store, scanned during push
    bukstk_ram #(
        .WIDTH (bukstk_pkg::KEY_W),
        .DEPTH (DEPTH)
    ) u_key_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (key_wdata),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (key_rdata)
    );

    // Record store: name, category, stock, price
    bukstk_ram #(
        .WIDTH (bukstk_pkg::REC_W),
        .DEPTH (DEPTH)
    ) u_rec_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (rec_wdata),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rec_rdata)
    );

endmodule

FILE: design/bukstk_ram.sv
// Simple dual-port synchronous RAM, one write and one registered read port.
// Used for the key store and the record store. No package dependencies.
module bukstk_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Read port, data holds until the next read
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: design/bukstk_ctrl.sv
// Controller of the bounded unique-key stack: request sequencing, key search,
// count and limit register, response register. Depends on bukstk_pkg.
module bukstk_ctrl #(
    parameter int DEPTH = 256
) (
    input  logic                         clk,
    input  logic                         rst_n,
    // configuration
    input  logic                         cfg_valid,
    input  logic [bukstk_pkg::COUNT_W-1:0] cfg_data,
    // request / response
    input  logic                         cmd_valid,
    output logic                         cmd_ready,
    input  bukstk_pkg::cmd_t             cmd,
    output logic                         rsp_valid,
    input  logic                         rsp_ready,
    output bukstk_pkg::rsp_t             rsp,
    // memory side
    output logic                         rd_en,
    output logic [$clog2(DEPTH)-1:0]     rd_addr,
    input  logic [bukstk_pkg::KEY_W-1:0] key_rdata,
    input  bukstk_pkg::rec_t             rec_rdata,
    output logic                         wr_en,
    output logic [$clog2(DEPTH)-1:0]     wr_addr,
    output logic [bukstk_pkg::KEY_W-1:0] key_wdata,
    output bukstk_pkg::rec_t             rec_wdata
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int LW = (CW > bukstk_pkg::COUNT_W) ? CW : bukstk_pkg::COUNT_W;

    bukstk_pkg::state_t state_reg, state_next;
    bukstk_pkg::cmd_t   cmd_reg;
    bukstk_pkg::rsp_t   rsp_reg, rsp_next;
    logic [CW-1:0]      count_reg, count_next;
    logic [AW-1:0]      idx_reg, idx_next;
    logic               cmp_valid_reg, cmp_valid_next;
    logic               dup_reg, dup_next;
    logic               rsp_valid_reg, rsp_valid_next;
    logic [bukstk_pkg::COUNT_W-1:0] max_items_reg;

    logic          accept;
    logic          fire;
    logic          empty;
    logic          full;
    logic [AW-1:0] last_idx;
    logic [LW-1:0] limit_ext;
    logic [LW-1:0] max_ext;
    logic [LW-1:0] count_ext;
    logic [LW-1:0] new_count_ext;

    assign accept    = cmd_valid && cmd_ready;
    assign fire      = (state_reg == bukstk_pkg::S_FINISH) && (!rsp_valid_reg || rsp_ready);
    assign empty     = (count_reg == '0);
    assign last_idx  = AW'(count_reg - 1'b1);
    assign max_ext   = LW'(max_items_reg);
    assign limit_ext = (max_ext > LW'(DEPTH)) ? LW'(DEPTH) : max_ext;
    assign count_ext = LW'(count_reg);
    assign full      = (count_ext >= limit_ext);

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            bukstk_pkg::S_IDLE:
            begin
                if (cmd_valid)
                begin
                    if (empty)
                    begin
                        state_next = bukstk_pkg::S_FINISH;
                    end
                    else if (cmd.func == bukstk_pkg::FUNC_PUSH)
                    begin
                        state_next = bukstk_pkg::S_SEARCH;
                    end
                    else if (cmd.func == bukstk_pkg::FUNC_POP ||
                             cmd.func == bukstk_pkg::FUNC_PEEK)
                    begin
                        state_next = bukstk_pkg::S_READ;
                    end
                    else
                    begin
                        state_next = bukstk_pkg::S_FINISH;
                    end
                end
            end
            bukstk_pkg::S_SEARCH:
            begin
                if (idx_reg == last_idx)
                begin
                    state_next = bukstk_pkg::S_DRAIN;
                end
            end
            bukstk_pkg::S_DRAIN:  state_next = bukstk_pkg::S_FINISH;
            bukstk_pkg::S_READ:   state_next = bukstk_pkg::S_FINISH;
            bukstk_pkg::S_FINISH:
            begin
                if (fire)
                begin
                    state_next = bukstk_pkg::S_IDLE;
                end
            end
            default:              state_next = bukstk_pkg::S_IDLE;
        endcase
    end

    // State-driven outputs: handshake and memory reads
    always_comb
    begin
        cmd_ready = 1'b0;
        rd_en     = 1'b0;
        rd_addr   = idx_reg;
        unique case (state_reg)
            bukstk_pkg::S_IDLE:   cmd_ready = 1'b1;
            bukstk_pkg::S_SEARCH: rd_en     = 1'b1;
            bukstk_pkg::S_READ:
            begin
                rd_en   = 1'b1;
                rd_addr = last_idx;
            end
            default:              rd_en = 1'b0;
        endcase
    end

    // Search bookkeeping: one key read issued per cycle, compared in the next cycle
    always_comb
    begin
        idx_next       = idx_reg;
        cmp_valid_next = (state_reg == bukstk_pkg::S_SEARCH);
        dup_next       = dup_reg;
        if (accept)
        begin
            idx_next = '0;
            dup_next = 1'b0;
        end
        else if (state_reg == bukstk_pkg::S_SEARCH)
        begin
            idx_next = idx_reg + 1'b1;
        end
        if (cmp_valid_reg && (key_rdata == cmd_reg.item_key))
        begin
            dup_next = 1'b1;
        end
    end

    // Operation result and stack update
    always_comb
    begin
        count_next = count_reg;
        wr_en      = 1'b0;
        rsp_next   = '0;
        rsp_next.status = bukstk_pkg::STAT_OK;
        case (cmd_reg.func) inside
            bukstk_pkg::FUNC_PUSH:
            begin
                if (dup_reg)
                begin
                    rsp_next.status = bukstk_pkg::STAT_DUP;
                end
                else if (full)
                begin
                    rsp_next.status = bukstk_pkg::STAT_FULL;
                end
                else
                begin
                    wr_en      = fire;
                    count_next = count_reg + 1'b1;
                end
            end
            bukstk_pkg::FUNC_POP,
            bukstk_pkg::FUNC_PEEK:
            begin
                if (empty)
                begin
                    rsp_next.status = bukstk_pkg::STAT_EMPTY;
                end
                else
                begin
                    rsp_next.out_key      = key_rdata;
                    rsp_next.out_name     = rec_rdata.name;
                    rsp_next.out_category = rec_rdata.category;
                    rsp_next.out_stock    = rec_rdata.stock;
                    rsp_next.out_price    = rec_rdata.price;
                    if (cmd_reg.func == bukstk_pkg::FUNC_POP)
                    begin
                        count_next = count_reg - 1'b1;
                    end
                end
            end
            default:
            begin
                rsp_next.status = bukstk_pkg::STAT_OK;
            end
        endcase
        new_count_ext  = LW'(count_next);
        rsp_next.count = new_count_ext[bukstk_pkg::COUNT_W-1:0];
    end

    // Push write port
    assign wr_addr            = count_reg[AW-1:0];
    assign key_wdata          = cmd_reg.item_key;
    assign rec_wdata.name     = cmd_reg.item_name;
    assign rec_wdata.category = cmd_reg.item_category;
    assign rec_wdata.stock    = cmd_reg.item_stock;
    assign rec_wdata.price    = cmd_reg.item_price;

    // Response valid: set on completion, cleared when taken
    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        if (fire)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= bukstk_pkg::S_IDLE;
            count_reg     <= '0;
            idx_reg       <= '0;
            cmp_valid_reg <= 1'b0;
            dup_reg       <= 1'b0;
            rsp_valid_reg <= 1'b0;
            max_items_reg <= bukstk_pkg::MAX_ITEMS_RESET;
        end
        else
        begin
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            cmp_valid_reg <= cmp_valid_next;
            dup_reg       <= dup_next;
            rsp_valid_reg <= rsp_valid_next;
            if (fire)
            begin
                count_reg <= count_next;
            end
            if (cfg_valid)
            begin
                max_items_reg <= cfg_data;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg <= cmd;
        end
        if (fire)
        begin
            rsp_reg <= rsp_next;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule
